// ===== design/bba_pkg.sv =====
// shared types and codes of the bitmap block allocator
package bba_pkg;

    localparam int OWNER_W = 4;
    localparam int COUNT_W = 8;
    localparam int FREED_W = 5;

    typedef enum logic
    {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        STAT_OK         = 2'd0,
        STAT_OWNER_BUSY = 2'd1,
        STAT_NO_SPACE   = 2'd2,
        STAT_NOT_FOUND  = 2'd3
    } status_t;

    typedef struct packed
    {
        action_t              action;
        logic [OWNER_W-1:0]   owner_id;
        logic [COUNT_W-1:0]   block_count;
    } bba_req_t;

    typedef struct packed
    {
        status_t              status;
        logic [1:0]           cyl_index;
        logic                 trk_index;
        logic [1:0]           sec_index;
        logic                 grant_valid;
        logic [FREED_W-1:0]   freed_count;
        logic                 last_result;
    } bba_rsp_t;

    typedef struct packed
    {
        logic clr;
        logic step;
    } bba_scan_ctl_t;

endpackage

// ===== design/bba_ram.sv =====
// generic single-port ram with registered read
module bba_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 24
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/bba_scan_ctr.sv =====
// block scan counter: linear index plus cylinder, track, sector position
module bba_scan_ctr
    import bba_pkg::*;
#(
    parameter int CYLINDERS = 3,
    parameter int TRACKS    = 2,
    parameter int SECTORS   = 4,
    localparam int BLOCKS   = CYLINDERS * TRACKS * SECTORS,
    localparam int BW       = (BLOCKS > 1) ? $clog2(BLOCKS) : 1,
    localparam int CYW      = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1,
    localparam int TW       = (TRACKS > 1) ? $clog2(TRACKS) : 1,
    localparam int SW       = (SECTORS > 1) ? $clog2(SECTORS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bba_scan_ctl_t ctl,
    output logic [BW-1:0] idx,
    output logic [CYW-1:0] cyl,
    output logic [TW-1:0] trk,
    output logic [SW-1:0] sec,
    output logic          last
);

    logic [BW-1:0]  idx_reg, idx_next;
    logic [CYW-1:0] cyl_reg, cyl_next;
    logic [TW-1:0]  trk_reg, trk_next;
    logic [SW-1:0]  sec_reg, sec_next;
    logic           sec_wrap, trk_wrap, cyl_wrap;

    assign sec_wrap = (sec_reg == SW'(SECTORS - 1));
    assign trk_wrap = (trk_reg == TW'(TRACKS - 1));
    assign cyl_wrap = (cyl_reg == CYW'(CYLINDERS - 1));
    assign last     = (idx_reg == BW'(BLOCKS - 1));

    always_comb
    begin
        idx_next = idx_reg;
        cyl_next = cyl_reg;
        trk_next = trk_reg;
        sec_next = sec_reg;
        if (ctl.clr)
        begin
            idx_next = '0;
            cyl_next = '0;
            trk_next = '0;
            sec_next = '0;
        end
        else if (ctl.step)
        begin
            idx_next = last ? '0 : idx_reg + BW'(1);
            if (!sec_wrap)
            begin
                sec_next = sec_reg + SW'(1);
            end
            else
            begin
                sec_next = '0;
                if (!trk_wrap)
                begin
                    trk_next = trk_reg + TW'(1);
                end
                else
                begin
                    trk_next = '0;
                    cyl_next = cyl_wrap ? '0 : cyl_reg + CYW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cyl_reg <= '0;
            trk_reg <= '0;
            sec_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cyl_reg <= cyl_next;
            trk_reg <= trk_next;
            sec_reg <= sec_next;
        end
    end

    assign idx = idx_reg;
    assign cyl = cyl_reg;
    assign trk = trk_reg;
    assign sec = sec_reg;

endmodule

// ===== design/bitmap_block_allocator_top.sv =====
// top level of the first-fit bitmap block allocator
//
// first-fit allocator over CYLINDERS x TRACKS x SECTORS disk blocks, numbered
// cylinder, then track, then sector. one request is taken at a time: req_ready
// is high only while the sequencer is idle. an allocate request whose owner is
// already active (or has an id of OWNERS or above) answers status 1, one that
// asks for more blocks than are free answers status 2. a granted allocate walks
// the blocks with a scan counter, one block per cycle while the response side
// does not stall, and hands out one response per granted block, the last one
// marked. a release walks every block through the single port of the owner ram
// (registered read, so the compare comes in the cycle after the scan) and
// answers once with the freed count. a response waits in an output register,
// and the next request is taken while it waits. the free-block total is kept
// as a running count, so no scan is needed to refuse a request. no clearing
// pass after reset: the owner ram output is only used where the used bit is set.
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int CYLINDERS = 3,
    parameter int TRACKS    = 2,
    parameter int SECTORS   = 4,
    parameter int OWNERS    = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bba_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bba_rsp_t rsp_data
);

    localparam int BLOCKS = CYLINDERS * TRACKS * SECTORS;
    localparam int BW     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CYW    = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
    localparam int TW     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int SW     = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int OW     = $clog2(OWNERS);
    localparam int FW     = $clog2(BLOCKS + 1);
    localparam int CW     = (FW > COUNT_W) ? FW : COUNT_W;

    // sequencer states
    typedef enum logic [5:0]
    {
        S_IDLE    = 6'b000001,
        S_DECIDE  = 6'b000010,
        S_ALLOC   = 6'b000100,
        S_REL     = 6'b001000,
        S_REL_END = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    bba_req_t            req_reg, req_next;
    logic [BLOCKS-1:0]   used_reg, used_next;
    logic [OWNERS-1:0]   active_reg, active_next;
    logic [FW-1:0]       free_cnt_reg, free_cnt_next;
    logic [COUNT_W-1:0]  grant_cnt_reg, grant_cnt_next;
    logic [FREED_W-1:0]  freed_reg, freed_next;
    status_t             pend_status_reg, pend_status_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [BW-1:0]       chk_idx_reg, chk_idx_next;
    logic                rsp_valid_reg, rsp_valid_next;
    bba_rsp_t            rsp_reg, rsp_next;

    // scan counter and owner ram
    bba_scan_ctl_t       scan_ctl;
    logic [BW-1:0]       scan_idx;
    logic [CYW-1:0]      scan_cyl;
    logic [TW-1:0]       scan_trk;
    logic [SW-1:0]       scan_sec;
    logic                scan_last;
    logic                ram_we;
    logic [OWNER_W-1:0]  ram_rdata;

    // decision terms
    logic                out_free;
    logic                id_bad;
    logic [OW-1:0]       oidx;
    logic                owner_busy;
    logic                short_space;
    logic                cur_free;
    logic                grant_last;
    logic                hit;

    bba_scan_ctr #(
        .CYLINDERS (CYLINDERS),
        .TRACKS    (TRACKS),
        .SECTORS   (SECTORS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .idx   (scan_idx),
        .cyl   (scan_cyl),
        .trk   (scan_trk),
        .sec   (scan_sec),
        .last  (scan_last)
    );

    // owner id per block; entries are only used where the used bit is set
    bba_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (BLOCKS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (scan_idx),
        .wdata (req_reg.owner_id),
        .rdata (ram_rdata)
    );

    // response register can take a new value this cycle
    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign id_bad      = (32'(req_reg.owner_id) >= 32'(OWNERS));
    assign oidx        = OW'(req_reg.owner_id);
    assign owner_busy  = id_bad || active_reg[oidx];
    assign short_space = (CW'(free_cnt_reg) < CW'(req_reg.block_count));
    assign cur_free    = !used_reg[scan_idx];
    assign grant_last  = (grant_cnt_reg == (req_reg.block_count - COUNT_W'(1)));
    // release compare comes in the cycle after the scan (registered ram read)
    assign hit         = chk_valid_reg && used_reg[chk_idx_reg]
                         && (ram_rdata == req_reg.owner_id);

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        used_next        = used_reg;
        active_next      = active_reg;
        free_cnt_next    = free_cnt_reg;
        grant_cnt_next   = grant_cnt_reg;
        freed_next       = freed_reg;
        pend_status_next = pend_status_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;
        scan_ctl         = '0;
        ram_we           = 1'b0;

        // release side: free one block owned by the requester
        if (hit)
        begin
            used_next[chk_idx_reg] = 1'b0;
            free_cnt_next          = free_cnt_reg + FW'(1);
            freed_next             = freed_reg + FREED_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                freed_next     = '0;
                grant_cnt_next = '0;
                scan_ctl.clr   = 1'b1;
                if (req_reg.action == ACT_ALLOC)
                begin
                    if (owner_busy)
                    begin
                        pend_status_next = STAT_OWNER_BUSY;
                        state_next       = S_EMIT;
                    end
                    else if (short_space)
                    begin
                        pend_status_next = STAT_NO_SPACE;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        active_next[oidx] = 1'b1;
                        pend_status_next  = STAT_OK;
                        // zero-block allocate only marks the owner active
                        state_next = (req_reg.block_count == '0) ? S_EMIT : S_ALLOC;
                    end
                end
                else
                begin
                    if (id_bad || !active_reg[oidx])
                    begin
                        pend_status_next = STAT_NOT_FOUND;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        active_next[oidx] = 1'b0;
                        pend_status_next  = STAT_OK;
                        state_next        = S_REL;
                    end
                end
            end

            S_ALLOC:
            begin
                if (!cur_free)
                begin
                    scan_ctl.step = 1'b1;
                end
                else if (out_free)
                begin
                    used_next[scan_idx]  = 1'b1;
                    free_cnt_next        = free_cnt_reg - FW'(1);
                    ram_we               = 1'b1;
                    scan_ctl.step        = 1'b1;
                    grant_cnt_next       = grant_cnt_reg + COUNT_W'(1);
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = STAT_OK;
                    rsp_next.cyl_index   = 2'(scan_cyl);
                    rsp_next.trk_index   = 1'(scan_trk);
                    rsp_next.sec_index   = 2'(scan_sec);
                    rsp_next.grant_valid = 1'b1;
                    rsp_next.freed_count = '0;
                    rsp_next.last_result = grant_last;
                    if (grant_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_REL:
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = scan_idx;
                if (scan_last)
                begin
                    state_next = S_REL_END;
                end
                else
                begin
                    scan_ctl.step = 1'b1;
                end
            end

            S_REL_END:
            begin
                // last block compare happens this cycle
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = pend_status_reg;
                    rsp_next.cyl_index   = '0;
                    rsp_next.trk_index   = 1'b0;
                    rsp_next.sec_index   = '0;
                    rsp_next.grant_valid = 1'b0;
                    rsp_next.freed_count = freed_reg;
                    rsp_next.last_result = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            active_reg    <= '0;
            free_cnt_reg  <= FW'(BLOCKS);
            chk_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            active_reg    <= active_next;
            free_cnt_reg  <= free_cnt_next;
            chk_valid_reg <= chk_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        grant_cnt_reg   <= grant_cnt_next;
        freed_reg       <= freed_next;
        pend_status_reg <= pend_status_next;
        chk_idx_reg     <= chk_idx_next;
        rsp_reg         <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// ===== design/bba_checker.sv =====
// port-level checks of the block allocator, bound to the top level
module bba_checker
    import bba_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input bba_req_t req_data,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input bba_rsp_t rsp_data
);

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed or dropped");

    // one request at a time: ready drops after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a granted block always comes with ok status and no freed count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.grant_valid |->
            rsp_data.status == STAT_OK && rsp_data.freed_count == '0)
        else $error("grant with bad status or freed count");

    // a response without a grant is always the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.grant_valid |-> rsp_data.last_result)
        else $error("non-grant response not marked last");

    // refusals carry no freed count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != STAT_OK |-> rsp_data.freed_count == '0)
        else $error("refused request reports freed blocks");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

// ===== bench/tb_bitmap_block_allocator_top.sv =====
// self-checking testbench of the first-fit bitmap block allocator
`timescale 1ns / 100ps

module tb_bitmap_block_allocator_top;
    import bba_pkg::*;

    // disk geometry and owner table size, handed to the block as parameters
    localparam int CYLS       = 3;
    localparam int TRKS       = 2;
    localparam int SECS       = 4;
    localparam int N_OWNERS   = 16;
    localparam int N_BLOCKS   = CYLS * TRKS * SECS;
    // cycles with no request and no response taken before the run is abandoned
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_WAIT  = 40;

    // one entry of the request queue: a request, or a marker that makes the
    // driver hold off until every owed response has come back
    typedef struct {
        bit       hold_until_drained;
        bba_req_t req;
    } cmd_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bba_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bba_rsp_t rsp_data;

    cmd_t     cmd_q[$];
    bba_rsp_t owed_rsp_q[$];

    // mirror of the allocator: used bit and owner per block, busy flag per owner
    bit         blk_used[N_BLOCKS];
    logic [3:0] blk_owner[N_BLOCKS];
    bit         owner_busy[N_OWNERS];

    int err_count   = 0;
    int sent_count  = 0;
    int rsp_count   = 0;
    int idle_cycles = 0;

    bitmap_block_allocator_top #(
        .CYLINDERS (CYLS),
        .TRACKS    (TRKS),
        .SECTORS   (SECS),
        .OWNERS    (N_OWNERS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one line per mismatch, counted for the final verdict
    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch at response %0d: %s got %0d expected %0d",
                 rsp_count, what, got, want);
        err_count++;
    endtask

    // applies one accepted request to the mirror and queues the responses
    // the allocator owes for it
    function automatic void apply_alloc_request(bba_req_t r);
        bba_rsp_t rsp;
        int       n_free;
        int       granted;
        int       freed;
        int       want;
        rsp             = '0;
        rsp.last_result = 1'b1;
        want            = r.block_count;
        n_free          = 0;
        granted         = 0;
        freed           = 0;
        if (r.action == ACT_ALLOC)
        begin
            // an active owner (or one without a table slot) is refused outright
            if (r.owner_id >= N_OWNERS || owner_busy[r.owner_id])
            begin
                rsp.status = STAT_OWNER_BUSY;
                owed_rsp_q.push_back(rsp);
                return;
            end
            foreach (blk_used[b])
                if (!blk_used[b])
                    n_free++;
            if (n_free < want)
            begin
                rsp.status = STAT_NO_SPACE;
                owed_rsp_q.push_back(rsp);
                return;
            end
            owner_busy[r.owner_id] = 1'b1;
            // zero-block grant: owner turns active holding nothing, one plain ok
            if (want == 0)
            begin
                rsp.status = STAT_OK;
                owed_rsp_q.push_back(rsp);
                return;
            end
            // first fit in scan order: cylinder, then track, then sector
            for (int b = 0; b < N_BLOCKS && granted < want; b++)
            begin
                if (!blk_used[b])
                begin
                    blk_used[b]     = 1'b1;
                    blk_owner[b]    = r.owner_id;
                    rsp             = '0;
                    rsp.status      = STAT_OK;
                    rsp.cyl_index   = 2'(b / (TRKS * SECS));
                    rsp.trk_index   = 1'((b / SECS) % TRKS);
                    rsp.sec_index   = 2'(b % SECS);
                    rsp.grant_valid = 1'b1;
                    rsp.last_result = (granted + 1 == want);
                    owed_rsp_q.push_back(rsp);
                    granted++;
                end
            end
        end
        else
        begin
            if (r.owner_id >= N_OWNERS || !owner_busy[r.owner_id])
            begin
                rsp.status = STAT_NOT_FOUND;
                owed_rsp_q.push_back(rsp);
                return;
            end
            foreach (blk_used[b])
            begin
                if (blk_used[b] && blk_owner[b] == r.owner_id)
                begin
                    blk_used[b] = 1'b0;
                    freed++;
                end
            end
            owner_busy[r.owner_id] = 1'b0;
            rsp.status      = STAT_OK;
            rsp.freed_count = FREED_W'(freed);
            owed_rsp_q.push_back(rsp);
        end
    endfunction

    task automatic add_request(action_t act, int id, int cnt);
        cmd_t c;
        c.hold_until_drained = 1'b0;
        c.req.action         = act;
        c.req.owner_id       = OWNER_W'(id);
        c.req.block_count    = COUNT_W'(cnt);
        cmd_q.push_back(c);
    endtask

    task automatic add_drain_pause();
        cmd_t c;
        c.hold_until_drained = 1'b1;
        c.req                = '0;
        cmd_q.push_back(c);
    endtask

    // request driver: takes the next request from cmd_q, idles about 27% of
    // the time except for a calm stretch, and honors drain markers
    always @(posedge clk)
    begin : drive_requests
        bit   taken;
        bit   raise;
        bit   calm;
        cmd_t c;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            taken = req_valid && req_ready;
            raise = 1'b0;
            calm  = (sent_count >= 70 && sent_count < 110);
            // a request that is offered but not yet taken stays put
            if (!req_valid || taken)
            begin
                if (cmd_q.size() != 0 && cmd_q[0].hold_until_drained)
                begin
                    // no check on the edge of an acceptance: the monitor may
                    // not have queued that request's responses yet
                    if (!taken && owed_rsp_q.size() == 0)
                        void'(cmd_q.pop_front());
                end
                else if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 27))
                begin
                    c = cmd_q.pop_front();
                    req_data <= c.req;
                    raise = 1'b1;
                    sent_count++;
                end
                req_valid <= raise;
            end
        end
    end

    // response monitor: checks each taken response against the oldest owed
    // one, then mirrors any request taken at the same edge, and throttles
    // rsp_ready at random outside a calm stretch
    always @(posedge clk)
    begin : watch_results
        bba_rsp_t want;
        bit       calm;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp_q.size() == 0)
                begin
                    flag_mismatch("unexpected response, status", rsp_data.status, -1);
                end
                else
                begin
                    want = owed_rsp_q.pop_front();
                    if (rsp_data.status != want.status)
                        flag_mismatch("status", rsp_data.status, want.status);
                    if (rsp_data.cyl_index != want.cyl_index)
                        flag_mismatch("cyl_index", rsp_data.cyl_index, want.cyl_index);
                    if (rsp_data.trk_index != want.trk_index)
                        flag_mismatch("trk_index", rsp_data.trk_index, want.trk_index);
                    if (rsp_data.sec_index != want.sec_index)
                        flag_mismatch("sec_index", rsp_data.sec_index, want.sec_index);
                    if (rsp_data.grant_valid != want.grant_valid)
                        flag_mismatch("grant_valid", rsp_data.grant_valid, want.grant_valid);
                    if (rsp_data.freed_count != want.freed_count)
                        flag_mismatch("freed_count", rsp_data.freed_count, want.freed_count);
                    if (rsp_data.last_result != want.last_result)
                        flag_mismatch("last_result", rsp_data.last_result, want.last_result);
                end
                rsp_count++;
            end
            if (req_valid && req_ready)
                apply_alloc_request(req_data);
            calm = (rsp_count >= 200 && rsp_count < 330);
            rsp_ready <= calm || ($urandom_range(0, 99) >= 27);
        end
    end

    // watchdog: too long without any request or response taken means a hang
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit [N_OWNERS-1:0] live;
        int                roll;
        int                id;
        int                cnt;
        action_t           act;
        live = '0;

        // directed part
        add_request(ACT_RELEASE, 3, 0);      // release of an owner never seen
        add_request(ACT_ALLOC, 0, 0);        // zero-block grant
        add_request(ACT_ALLOC, 0, 2);        // owner already active
        add_request(ACT_RELEASE, 0, 0);      // release of an owner holding nothing
        add_request(ACT_ALLOC, 15, 25);      // one more than the disk holds
        add_request(ACT_ALLOC, 15, 255);     // largest count
        add_request(ACT_ALLOC, 1, 24);       // whole disk, 24 responses
        add_request(ACT_ALLOC, 2, 1);        // disk full
        add_request(ACT_ALLOC, 2, 0);        // zero blocks still fit on a full disk
        add_request(ACT_RELEASE, 1, 0);      // frees all 24
        add_request(ACT_RELEASE, 2, 0);
        // fragmentation: free a hole in the middle, then fill it first
        add_request(ACT_ALLOC, 5, 3);
        add_request(ACT_ALLOC, 6, 4);
        add_request(ACT_ALLOC, 7, 2);
        add_request(ACT_RELEASE, 6, 0);
        add_request(ACT_ALLOC, 8, 6);
        add_request(ACT_ALLOC, 9, 15);       // no room left for this one
        add_request(ACT_ALLOC, 10, 13);      // takes exactly the rest
        add_request(ACT_RELEASE, 5, 0);
        add_request(ACT_RELEASE, 7, 0);
        add_request(ACT_RELEASE, 8, 0);
        add_request(ACT_RELEASE, 10, 0);
        add_drain_pause();
        add_request(ACT_RELEASE, 10, 128);   // owner gone again, count ignored

        // random part: mostly allocates to idle owners and releases of busy
        // ones, with some fully random noise
        for (int i = 0; i < 156; i++)
        begin
            if (i == 78)
                add_drain_pause();
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                act = action_t'($urandom_range(0, 1));
                id  = $urandom_range(0, N_OWNERS - 1);
                cnt = $urandom_range(0, 255);
            end
            else if (roll < 55)
            begin
                act = ACT_ALLOC;
                id  = $urandom_range(0, N_OWNERS - 1);
                for (int t = 0; t < 4 && live[id]; t++)
                    id = $urandom_range(0, N_OWNERS - 1);
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    cnt = 0;
                else if (roll < 80)
                    cnt = $urandom_range(1, 5);
                else if (roll < 95)
                    cnt = $urandom_range(6, 12);
                else
                    cnt = $urandom_range(13, N_BLOCKS);
            end
            else
            begin
                act = ACT_RELEASE;
                id  = $urandom_range(0, N_OWNERS - 1);
                for (int t = 0; t < 4 && !live[id]; t++)
                    id = $urandom_range(0, N_OWNERS - 1);
                cnt = $urandom_range(0, 255);
            end
            // rough guess of who is active, only to steer the choice of owner
            live[id] = (act == ACT_ALLOC);
            add_request(act, id, cnt);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the queue to empty and every owed response to arrive
        while (cmd_q.size() != 0 || req_valid || owed_rsp_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (owed_rsp_q.size() != 0)
            flag_mismatch("responses never delivered", 0, owed_rsp_q.size());

        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
